@@ rtl/flg_pkg.sv @@
// Shared constants, register codes and the sine table generator of the flanger delay line.
package flg_pkg;

  localparam int RING_LENGTH_DEF        = 512;
  localparam int SINE_TABLE_ENTRIES_DEF = 256;
  localparam int PHASE_BITS_DEF         = 24;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int STEP_W   = 16;
  localparam int BASE_W   = 17;
  localparam int SWING_W  = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_DELAY    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MOD_SWING     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WET_GAIN      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BYPASS        = 3'd5;

  // Register values after reset.
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST    = 16'd655;
  localparam logic [BASE_W-1:0]  BASE_DELAY_RST    = 17'd7200;
  localparam logic [SWING_W-1:0] MOD_SWING_RST     = 16'd12288;
  localparam logic [GAIN_W-1:0]  WET_GAIN_RST      = 16'd16384;
  localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST = 16'd9830;

  // Quarter-wave sine point in Q1.15, from a 7th-order polynomial in Q16.
  // The argument k is a table position and sh scales it onto a 2^16 quarter turn.
  function automatic logic [15:0] poly_sine(input int k, input int sh);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x  = longint'(k) << sh;
    x2 = (x * x) >> 16;
    t  = 64'd5223 - ((64'd307 * x2) >> 16);
    t  = 64'd42334 - ((t * x2) >> 16);
    t  = 64'd102944 - ((t * x2) >> 16);
    t  = ((t * x) >> 16) >> 1;
    if (t > 64'd32767) begin
      t = 64'd32767;
    end
    return t[15:0];
  endfunction

endpackage

@@ rtl/flanger_delay_line.sv @@
// Flanger: LFO-modulated fractional delay line with feedback and saturating mix.
// Each accepted word is walked by the sequencer through the sine table, swing multiplier, ring
// read, interpolation and gains (states MUL, ADDR, INTERP, GAIN, SUM; BYP in bypass). SUM and
// BYP wait for a free output slot, and no new word is taken before the state returns to IDLE.
// Reset: registers take their defaults, pointer and LFO phase clear; the ring reads as zero
// through a fill mark until written, so no clearing pass is needed.
module flanger_delay_line #(
  parameter int RING_LENGTH        = flg_pkg::RING_LENGTH_DEF,
  parameter int SINE_TABLE_ENTRIES = flg_pkg::SINE_TABLE_ENTRIES_DEF,
  parameter int PHASE_BITS         = flg_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [flg_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [flg_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [flg_pkg::ADDR_W-1:0]          paddr,
  input  logic [flg_pkg::DATA_W-1:0]          pwdata,
  output logic [flg_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int AW       = $clog2(RING_LENGTH);
  localparam int IDX_W    = $clog2(SINE_TABLE_ENTRIES);
  localparam int QW       = IDX_W - 2;
  localparam int QUARTER  = SINE_TABLE_ENTRIES / 4;
  localparam int LUT_SH   = 16 - QW;
  localparam int D_W      = 21;
  localparam int SW       = flg_pkg::SAMPLE_W;
  localparam logic signed [D_W-1:0] D_MIN = D_W'(256);
  localparam logic signed [D_W-1:0] D_MAX = D_W'((RING_LENGTH - 2) * 256);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_ADDR   = 7'b0000100,
    S_INTERP = 7'b0001000,
    S_GAIN   = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_BYP    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [flg_pkg::STEP_W-1:0]  phase_step_r;
  logic [flg_pkg::BASE_W-1:0]  base_delay_r;
  logic [flg_pkg::SWING_W-1:0] mod_swing_r;
  logic [flg_pkg::GAIN_W-1:0]  wet_gain_r;
  logic [flg_pkg::GAIN_W-1:0]  feedback_gain_r;
  logic                        bypass_r;

  logic                       cfg_wr;
  logic [flg_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[flg_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= flg_pkg::PHASE_STEP_RST;
      base_delay_r    <= flg_pkg::BASE_DELAY_RST;
      mod_swing_r     <= flg_pkg::MOD_SWING_RST;
      wet_gain_r      <= flg_pkg::WET_GAIN_RST;
      feedback_gain_r <= flg_pkg::FEEDBACK_GAIN_RST;
      bypass_r        <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        flg_pkg::REG_PHASE_STEP:    phase_step_r    <= pwdata[flg_pkg::STEP_W-1:0];
        flg_pkg::REG_BASE_DELAY:    base_delay_r    <= pwdata[flg_pkg::BASE_W-1:0];
        flg_pkg::REG_MOD_SWING:     mod_swing_r     <= pwdata[flg_pkg::SWING_W-1:0];
        flg_pkg::REG_WET_GAIN:      wet_gain_r      <= pwdata[flg_pkg::GAIN_W-1:0];
        flg_pkg::REG_FEEDBACK_GAIN: feedback_gain_r <= pwdata[flg_pkg::GAIN_W-1:0];
        flg_pkg::REG_BYPASS:        bypass_r        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      flg_pkg::REG_PHASE_STEP:    prdata = flg_pkg::DATA_W'(phase_step_r);
      flg_pkg::REG_BASE_DELAY:    prdata = flg_pkg::DATA_W'(base_delay_r);
      flg_pkg::REG_MOD_SWING:     prdata = flg_pkg::DATA_W'(mod_swing_r);
      flg_pkg::REG_WET_GAIN:      prdata = flg_pkg::DATA_W'(wet_gain_r);
      flg_pkg::REG_FEEDBACK_GAIN: prdata = flg_pkg::DATA_W'(feedback_gain_r);
      flg_pkg::REG_BYPASS:        prdata = flg_pkg::DATA_W'(bypass_r);
      default:                    prdata = '0;
    endcase
  end

  // Quarter-wave sine table, worked out at elaboration.
  logic [15:0] sine_lut [QUARTER+1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_lut
    assign sine_lut[k] = flg_pkg::poly_sine(k, LUT_SH);
  end

  // Datapath state.
  logic [AW-1:0]          wp_r;
  logic                   wrapped_r;
  logic [PHASE_BITS-1:0]  phase_r;
  logic signed [SW-1:0]   x_r;
  logic signed [16:0]     sine_r;
  logic signed [33:0]     swing_prod_r;
  logic [7:0]             wb_r;
  logic                   va_r, vb_r;
  logic signed [SW-1:0]   rd_a_r, rd_b_r;
  logic signed [33:0]     pa_r, pb_r;
  logic signed [40:0]     fb_prod_r, wet_prod_r;
  logic                   out_valid_r;
  logic signed [SW-1:0]   out_sample_r;

  logic signed [SW-1:0]   ring [RING_LENGTH];

  // Sine lookup from the top bits of the phase, folded over the four quadrants.
  logic [IDX_W-1:0]  lut_idx;
  logic [1:0]        quad;
  logic [QW-1:0]     pos;
  logic [QW:0]       lut_addr;
  logic signed [16:0] sine_val;

  always_comb begin
    lut_idx  = phase_r[PHASE_BITS-1 -: IDX_W];
    quad     = lut_idx[IDX_W-1 -: 2];
    pos      = lut_idx[QW-1:0];
    lut_addr = quad[0] ? ((QW+1)'(QUARTER) - {1'b0, pos}) : {1'b0, pos};
    sine_val = quad[1] ? -$signed({1'b0, sine_lut[lut_addr]})
                       : $signed({1'b0, sine_lut[lut_addr]});
  end

  // Delay clamp and ring addresses.
  logic signed [D_W-1:0] d_raw, d_clamp;
  logic [AW-1:0]         di, i1, i2;
  logic [7:0]            fr;

  always_comb begin
    d_raw = D_W'($signed({1'b0, base_delay_r})) + D_W'(swing_prod_r >>> 15);
    if (d_raw < D_MIN) begin
      d_clamp = D_MIN;
    end else if (d_raw > D_MAX) begin
      d_clamp = D_MAX;
    end else begin
      d_clamp = d_raw;
    end
    fr = d_clamp[7:0];
    di = d_clamp[AW+7:8] + AW'(fr != 8'd0);
    i1 = wp_r - di;
    i2 = i1 + AW'(1);
  end

  // Interpolation and gains.
  logic signed [SW-1:0] a_val, b_val;
  logic [8:0]           wa;
  logic signed [34:0]   interp_sum;
  logic signed [SW-1:0] delayed;
  logic signed [26:0]   w_sum, y_sum;
  logic signed [SW-1:0] w_sat, y_sat;

  function automatic logic signed [SW-1:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end
    return v[SW-1:0];
  endfunction

  always_comb begin
    a_val      = va_r ? rd_a_r : '0;
    b_val      = vb_r ? rd_b_r : '0;
    wa         = 9'd256 - {1'b0, wb_r};
    interp_sum = 35'(pa_r) + 35'(pb_r);
    delayed    = interp_sum[31:8];
    w_sum      = 27'(x_r) + 27'($signed(fb_prod_r[40:15]));
    y_sum      = 27'(x_r) + 27'($signed(wet_prod_r[40:15]));
    w_sat      = sat24(w_sum);
    y_sat      = sat24(y_sum);
  end

  logic slot_free;
  logic in_fire;
  logic sum_fire;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign sum_fire  = (state_r == S_SUM) && slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = bypass_r ? S_BYP : S_MUL;
      S_MUL:    state_nxt = S_ADDR;
      S_ADDR:   state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_GAIN;
      S_GAIN:   state_nxt = S_SUM;
      S_SUM:    if (slot_free) state_nxt = S_IDLE;
      S_BYP:    if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (sum_fire) begin
        wp_r    <= wp_r + AW'(1);
        phase_r <= phase_r + PHASE_BITS'(phase_step_r);
        if (wp_r == {AW{1'b1}}) begin
          wrapped_r <= 1'b1;
        end
      end
      if (sum_fire || ((state_r == S_BYP) && slot_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r    <= in_sample_in;
      sine_r <= sine_val;
    end
    if (state_r == S_MUL) begin
      swing_prod_r <= $signed({1'b0, mod_swing_r}) * sine_r;
    end
    if (state_r == S_ADDR) begin
      wb_r <= (fr == 8'd0) ? 8'd0 : 8'd0 - fr;
      // Entries not yet written since reset read as zero.
      va_r <= wrapped_r || (i1 < wp_r);
      vb_r <= wrapped_r || (i2 < wp_r);
    end
    if (state_r == S_INTERP) begin
      pa_r <= a_val * $signed({1'b0, wa});
      pb_r <= b_val * $signed({1'b0, 1'b0, wb_r});
    end
    if (state_r == S_GAIN) begin
      fb_prod_r  <= delayed * $signed({1'b0, feedback_gain_r});
      wet_prod_r <= delayed * $signed({1'b0, wet_gain_r});
    end
    if (sum_fire) begin
      out_sample_r <= y_sat;
    end else if ((state_r == S_BYP) && slot_free) begin
      out_sample_r <= x_r;
    end
  end

  // Delay ring: two read addresses, one write, registered read data.
  always_ff @(posedge clk) begin
    if (state_r == S_ADDR) begin
      rd_a_r <= ring[i1];
      rd_b_r <= ring[i2];
    end
    if (sum_fire) begin
      ring[wp_r] <= w_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // The older tap never lands on the entry about to be written.
  a_tap_not_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR) |-> (i1 != wp_r))
    else $error("delay tap reads the write pointer entry");

  // The write pointer only moves together with a new result word.
  a_wp_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r != $past(wp_r)) |-> out_valid_r)
    else $error("write pointer moved without a result word");

  // Bypass leaves the LFO phase untouched.
  a_byp_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BYP) |=> (phase_r == $past(phase_r)))
    else $error("LFO phase moved in bypass");

  // An accepted word enters either the bypass path or the processing path.
  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ((state_r == S_MUL) || (state_r == S_BYP)))
    else $error("accepted word took no path");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench of the flanger delay line: predicts every output word and checks it.
module testbench;

  typedef logic signed [flg_pkg::SAMPLE_W-1:0] sample_t;

  localparam int     RING_LEN      = flg_pkg::RING_LENGTH_DEF;
  localparam int     SINE_ENTRIES  = flg_pkg::SINE_TABLE_ENTRIES_DEF;
  localparam int     QUARTER_PTS   = SINE_ENTRIES / 4;
  localparam int     PHASE_W       = flg_pkg::PHASE_BITS_DEF;
  localparam longint SAT_HI        = 64'sd8388607;
  localparam longint SAT_LO        = -64'sd8388608;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     MAX_REPORTED  = 10;
  localparam int     LIMIT_CYCLES  = 500000;
  localparam int     PHASES        = 7;
  localparam int     PHASE_ITEMS   = 100;

  // Addresses past the register list, which the block must ignore.
  localparam logic [flg_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [flg_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  class flanger_scoreboard;
    sample_t                 ring[RING_LEN];
    int                      wr_ptr;
    logic [PHASE_W-1:0]      lfo_phase;
    logic [flg_pkg::STEP_W-1:0]  phase_step;
    logic [flg_pkg::BASE_W-1:0]  base_delay;
    logic [flg_pkg::SWING_W-1:0] mod_swing;
    logic [flg_pkg::GAIN_W-1:0]  wet_gain;
    logic [flg_pkg::GAIN_W-1:0]  fb_gain;
    logic                    bypass_on;
    longint                  quarter_sine[QUARTER_PTS+1];
    sample_t                 expected_out[$];
    int                      error_count;

    function new();
      for (int k = 0; k <= QUARTER_PTS; k++) begin
        quarter_sine[k] = sine_point(k);
      end
      for (int i = 0; i < RING_LEN; i++) begin
        ring[i] = '0;
      end
      wr_ptr      = 0;
      lfo_phase   = '0;
      phase_step  = flg_pkg::PHASE_STEP_RST;
      base_delay  = flg_pkg::BASE_DELAY_RST;
      mod_swing   = flg_pkg::MOD_SWING_RST;
      wet_gain    = flg_pkg::WET_GAIN_RST;
      fb_gain     = flg_pkg::FEEDBACK_GAIN_RST;
      bypass_on   = 1'b0;
      error_count = 0;
    endfunction

    // Odd polynomial in Q16 over a quarter turn, halved to Q15 and capped.
    function longint sine_point(int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      x  = (longint'(k) << 16) / QUARTER_PTS;
      x2 = (x * x) >> 16;
      t  = 64'd5223 - ((64'd307 * x2) >> 16);
      t  = 64'd42334 - ((t * x2) >> 16);
      t  = 64'd102944 - ((t * x2) >> 16);
      t  = ((t * x) >> 16) >> 1;
      return (t > 64'd32767) ? 64'sd32767 : longint'(t);
    endfunction

    function longint clip24(longint v);
      if (v > SAT_HI) begin
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        return SAT_LO;
      end
      return v;
    endfunction

    function void set_reg(logic [flg_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        flg_pkg::REG_PHASE_STEP:    phase_step = val[flg_pkg::STEP_W-1:0];
        flg_pkg::REG_BASE_DELAY:    base_delay = val[flg_pkg::BASE_W-1:0];
        flg_pkg::REG_MOD_SWING:     mod_swing  = val[flg_pkg::SWING_W-1:0];
        flg_pkg::REG_WET_GAIN:      wet_gain   = val[flg_pkg::GAIN_W-1:0];
        flg_pkg::REG_FEEDBACK_GAIN: fb_gain    = val[flg_pkg::GAIN_W-1:0];
        flg_pkg::REG_BYPASS:        bypass_on  = val[0];
        default: ;
      endcase
    endfunction

    // Runs one accepted word through the delay line and queues the output it must give.
    function void note_sample(sample_t s);
      longint x;
      longint sine;
      longint d;
      longint di;
      longint fr;
      longint a;
      longint b;
      longint delayed;
      longint w;
      longint y;
      int     idx;
      int     quad;
      int     pos;
      int     i1;
      int     i2;
      if (bypass_on) begin
        expected_out.push_back(s);
        return;
      end
      x    = s;
      idx  = int'((longint'(lfo_phase) * SINE_ENTRIES) >> PHASE_W);
      quad = (idx / QUARTER_PTS) % 4;
      pos  = idx % QUARTER_PTS;
      sine = (quad == 0 || quad == 2) ? quarter_sine[pos] : quarter_sine[QUARTER_PTS - pos];
      if (quad >= 2) begin
        sine = -sine;
      end
      d = longint'(base_delay) + ((longint'(mod_swing) * sine) >>> 15);
      if (d < 256) begin
        d = 256;
      end
      if (d > (RING_LEN - 2) * 256) begin
        d = (RING_LEN - 2) * 256;
      end
      // A fractional delay reads one entry further back and weights towards the newer one.
      di = d >>> 8;
      fr = d & 255;
      if (fr != 0) begin
        di = di + 1;
        fr = 256 - fr;
      end
      i1      = int'((wr_ptr + RING_LEN - di) % RING_LEN);
      i2      = (i1 + 1) % RING_LEN;
      a       = ring[i1];
      b       = ring[i2];
      delayed = (a * (256 - fr) + b * fr) >>> 8;
      w       = clip24(x + ((delayed * longint'(fb_gain)) >>> 15));
      y       = clip24(x + ((delayed * longint'(wet_gain)) >>> 15));
      ring[wr_ptr] = w[flg_pkg::SAMPLE_W-1:0];
      wr_ptr       = (wr_ptr + 1) % RING_LEN;
      lfo_phase    = lfo_phase + phase_step;
      expected_out.push_back(y[flg_pkg::SAMPLE_W-1:0]);
    endfunction

    function void log_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTED) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (expected_out.size() == 0) begin
        log_error($sformatf("output word %0d with nothing expected", got));
        return;
      end
      want = expected_out.pop_front();
      if (got !== want) begin
        log_error($sformatf("sample_out expected %0d, got %0d", want, got));
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  sample_t                       in_sample_in;
  logic                          out_valid;
  logic                          out_ready;
  sample_t                       out_sample_out;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [flg_pkg::ADDR_W-1:0]    paddr;
  logic [flg_pkg::DATA_W-1:0]    pwdata;
  logic [flg_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  flanger_scoreboard sb;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_requests;
  int                hold_served;
  int                cycle_count = 0;

  flanger_delay_line DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_sample(out_sample_out);
    end
  end

  // The receiver owns its long hold-off counter; the stimulus only asks for one.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    hold_served = 0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [flg_pkg::REG_IDX_W-1:0] idx,
                                input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fills the bits above a register's width with junk, which the block must drop.
  function automatic logic [31:0] with_junk(logic [31:0] v, int w);
    return v | ($urandom() << w);
  endfunction

  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return sample_t'(24'h7FFFFF);
      1: return sample_t'(24'h800000);
      2, 3: return sample_t'($signed($urandom_range(2047)) - 1024);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic program_all(input logic [15:0] step, input logic [16:0] base,
                             input logic [15:0] swing, input logic [15:0] wet,
                             input logic [15:0] fb, input logic byp);
    write_register(flg_pkg::REG_PHASE_STEP,    with_junk(32'(step), flg_pkg::STEP_W));
    write_register(flg_pkg::REG_BASE_DELAY,    with_junk(32'(base), flg_pkg::BASE_W));
    write_register(flg_pkg::REG_MOD_SWING,     with_junk(32'(swing), flg_pkg::SWING_W));
    write_register(flg_pkg::REG_WET_GAIN,      with_junk(32'(wet), flg_pkg::GAIN_W));
    write_register(flg_pkg::REG_FEEDBACK_GAIN, with_junk(32'(fb), flg_pkg::GAIN_W));
    write_register(flg_pkg::REG_BYPASS,        with_junk(32'(byp), 1));
  endtask

  task automatic program_phase(input int p);
    case (p)
      0: program_all(16'd655, 17'($urandom_range(256, 20000)), 16'($urandom_range(8000)),
                     16'd32768, 16'd32768, 1'b0);
      2: program_all(16'hFFFF, 17'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
      4: program_all(16'($urandom()), 17'($urandom()), 16'($urandom()), 16'd20000,
                     16'd20000, 1'b1);
      6: program_all(16'($urandom()), 17'h1FFFF, 16'($urandom()), 16'hFFFF, 16'hFFFF,
                     1'b0);
      default: program_all(16'($urandom()), 17'($urandom()), 16'($urandom()),
                           16'($urandom_range(65535)), 16'($urandom_range(40000)), 1'b0);
    endcase
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample_in  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_requests = 0;
    send_idle_pct = 26;
    recv_idle_pct = 69;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Settings after reset, with extreme inputs into an empty ring.
    send_word(sample_t'(24'h7FFFFF));
    send_word(sample_t'(24'h800000));
    send_word(sample_t'(0));
    send_word(sample_t'(-1));
    settle_idle();

    // Delay below one sample clamps to one; gains near 2.0 drive both sums into saturation.
    program_all(16'd0, 17'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    write_register(REG_SPARE_A, $urandom());
    write_register(REG_SPARE_B, $urandom());
    repeat (3) send_word(sample_t'(24'h7FFFFF));
    repeat (3) send_word(sample_t'(24'h800000));
    settle_idle();

    // Delay beyond the ring clamps to its far end; fastest LFO and widest swing.
    program_all(16'hFFFF, 17'h1FFFF, 16'hFFFF, 16'd32768, 16'd300, 1'b0);
    repeat (4) send_word(random_sample());
    settle_idle();

    // Bypass must leave the ring, pointer and phase untouched for the words after it.
    write_register(flg_pkg::REG_BYPASS, 32'd1);
    send_word(sample_t'(24'h7FFFFF));
    send_word(sample_t'(24'h800000));
    send_word(sample_t'(24'h5A5A5A));
    settle_idle();
    write_register(flg_pkg::REG_BYPASS, 32'd0);
    write_register(flg_pkg::REG_BASE_DELAY, 32'd300);
    send_word(random_sample());
    send_word(random_sample());
    settle_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 26;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_phase(p);
      if (p == 5) begin
        hold_requests++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_word(random_sample());
      end
      settle_idle();
    end

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
